[rtl/rptw_pkg.sv]
// Shared constants and control/status types for the radix page table walker.
package rptw_pkg;

  localparam int unsigned VPN_W      = 45;
  localparam int unsigned PPN_W      = 52;
  localparam int unsigned ENTRY_W    = 64;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned LEVELS     = 5;
  localparam int unsigned LVL_W      = 3;
  localparam int unsigned ROOT_W     = 6;
  localparam int unsigned FREE_W     = 7;
  localparam int unsigned NEXT_W     = FREE_W + 1;
  localparam int unsigned CFG_W      = FREE_W;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MAP   = 2'd1;
  localparam logic [1:0] ST_NO_FRAME = 2'd2;

  localparam logic [NEXT_W-1:0] FIRST_FREE_RST = NEXT_W'(1);

  typedef struct packed {
    logic       clear_step;
    logic       load_req;
    logic       read;
    logic       follow;
    logic       alloc;
    logic       leaf_write;
    logic       set_res;
    logic [1:0] res_status;
    logic       res_ppn_sel;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic frame_oor;
    logic entry_valid;
    logic last_level;
    logic alloc_fail;
    logic is_update;
  } sts_t;

endpackage

[rtl/rptw_datapath.sv]
// Datapath: frame memory, walk registers, allocator and result registers.
module rptw_datapath import rptw_pkg::*; #(
  parameter int unsigned FRAMES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 req_type_i,
  input  logic [VPN_W-1:0]     vpn_i,
  input  logic [PPN_W-1:0]     new_ppn_i,
  input  logic                 unmap_i,
  output logic [1:0]           status_o,
  output logic [PPN_W-1:0]     ppn_o
);

  localparam int unsigned FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned AW    = FW + IDX_W;
  localparam int unsigned DEPTH = FRAMES * (2 ** IDX_W);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_q;

  logic [AW-1:0]      clr_q, clr_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic [NEXT_W-1:0]  next_q, next_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [PPN_W-1:0]   frame_q, frame_d;
  logic               upd_q;
  logic [VPN_W-1:0]   vpn_q;
  logic [PPN_W-1:0]   new_ppn_q;
  logic               unmap_q;
  logic [1:0]         res_status_q;
  logic [PPN_W-1:0]   res_ppn_q;
  logic [1:0]         out_status_q;
  logic [PPN_W-1:0]   out_ppn_q;

  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      addr;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [ENTRY_W-1:0] mem_wd;
  logic [PPN_W-1:0]   entry_ppn;

  always_comb begin
    unique case (lvl_q)
      3'd0:    idx = vpn_q[44:36];
      3'd1:    idx = vpn_q[35:27];
      3'd2:    idx = vpn_q[26:18];
      3'd3:    idx = vpn_q[17:9];
      3'd4:    idx = vpn_q[8:0];
      default: idx = '0;
    endcase
  end

  assign addr      = {frame_q[FW-1:0], idx};
  assign entry_ppn = rd_q[ENTRY_W-1:PAGE_SHIFT];

  assign sts_o.clear_last  = (clr_q == AW'(DEPTH - 1));
  assign sts_o.frame_oor   = (frame_q >= PPN_W'(FRAMES));
  assign sts_o.entry_valid = rd_q[0];
  assign sts_o.last_level  = (lvl_q == LVL_W'(LEVELS - 1));
  assign sts_o.alloc_fail  = next_q[NEXT_W-1] || (32'(next_q) >= 32'(FRAMES));
  assign sts_o.is_update   = upd_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr;
    mem_wd = '0;
    if (cmd_i.clear_step) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
    end else if (cmd_i.alloc) begin
      mem_we = 1'b1;
      mem_wd = {PPN_W'(next_q), 11'b0, 1'b1};
    end else if (cmd_i.leaf_write) begin
      mem_we = 1'b1;
      mem_wd = unmap_q ? {rd_q[ENTRY_W-1:1], 1'b0} : {new_ppn_q, 11'b0, 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.read) begin
      rd_q <= mem[addr];
    end
  end

  always_comb begin
    clr_d   = cmd_i.clear_step ? clr_q + AW'(1) : clr_q;
    lvl_d   = lvl_q;
    next_d  = next_q;
    root_d  = root_q;
    frame_d = frame_q;
    if (cmd_i.load_req) begin
      lvl_d   = '0;
      frame_d = PPN_W'(root_q);
    end else if (cmd_i.follow) begin
      lvl_d   = lvl_q + LVL_W'(1);
      frame_d = entry_ppn;
    end else if (cmd_i.alloc) begin
      lvl_d   = lvl_q + LVL_W'(1);
      frame_d = PPN_W'(next_q);
      next_d  = next_q + NEXT_W'(1);
    end
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROOT_FRAME: root_d = cfg_data_i[ROOT_W-1:0];
        CFG_FIRST_FREE: next_d = {1'b0, cfg_data_i};
        default:        root_d = root_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      lvl_q  <= '0;
      next_q <= FIRST_FREE_RST;
      root_q <= '0;
    end else begin
      clr_q  <= clr_d;
      lvl_q  <= lvl_d;
      next_q <= next_d;
      root_q <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    if (cmd_i.load_req) begin
      upd_q     <= req_type_i;
      vpn_q     <= vpn_i;
      new_ppn_q <= new_ppn_i;
      unmap_q   <= unmap_i;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_ppn_q    <= cmd_i.res_ppn_sel ? entry_ppn : '0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_ppn_q    <= res_ppn_q;
    end
  end

  assign status_o = out_status_q;
  assign ppn_o    = out_ppn_q;

endmodule

[rtl/rptw_ctrl.sv]
// Controller: clearing sweep, walk sequencer and output word handshake.
module rptw_ctrl import rptw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.frame_oor) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_NO_MAP;
          state_d          = S_RESP;
        end else begin
          cmd_o.read = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d       = S_RESP;
        cmd_o.set_res = 1'b1;
        if (!sts_i.last_level) begin
          priority if (sts_i.entry_valid) begin
            cmd_o.set_res = 1'b0;
            cmd_o.follow  = 1'b1;
            state_d       = S_READ;
          end else if (!sts_i.is_update) begin
            cmd_o.res_status = ST_NO_MAP;
          end else if (sts_i.alloc_fail) begin
            cmd_o.res_status = ST_NO_FRAME;
          end else begin
            cmd_o.set_res = 1'b0;
            cmd_o.alloc   = 1'b1;
            state_d       = S_READ;
          end
        end else begin
          priority if (sts_i.is_update) begin
            cmd_o.leaf_write = 1'b1;
            cmd_o.res_status = ST_OK;
          end else if (sts_i.entry_valid) begin
            cmd_o.res_status  = ST_OK;
            cmd_o.res_ppn_sel = 1'b1;
          end else begin
            cmd_o.res_status = ST_NO_MAP;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/radix_page_table_walker.sv]
// Top level: five-level radix page table walker over an internal frame memory.
// Each level visited takes a frame memory read (S_READ), then a check or write (S_CHECK);
// a word is taken in S_IDLE, its result loaded out in S_RESP; a walk may stop early.
// S_RESP waits while the output is stalled; no new word is taken until the walk ends.
// Reset: the frame memory is cleared by a sweep over all FRAMES*512 entries, one entry a cycle;
// no word is accepted until the sweep ends, configuration writes are taken meanwhile.
module radix_page_table_walker import rptw_pkg::*; #(
  parameter int unsigned FRAMES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [VPN_W-1:0]     vpn_i,
  input  logic [PPN_W-1:0]     new_ppn_i,
  input  logic                 unmap_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [PPN_W-1:0]     ppn_o
);

  cmd_t cmd;
  sts_t sts;

  rptw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rptw_datapath #(
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_type_i (req_type_i),
    .vpn_i      (vpn_i),
    .new_ppn_i  (new_ppn_i),
    .unmap_i    (unmap_i),
    .status_o   (status_o),
    .ppn_o      (ppn_o)
  );

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_step |-> in_stall_o)
    else $error("word accepted during memory clear");

  a_alloc_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.alloc |-> !sts.alloc_fail)
    else $error("allocation issued with no free frame");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.read |-> !sts.frame_oor)
    else $error("table read from frame outside memory");

  a_load_shows_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("result loaded but not presented");

endmodule
